@@ hw/rtl/bba_pkg.sv @@
// shared types, codes and default sizes for the buddy block allocator
package bba_pkg;

	localparam int DEF_SMALLEST_BLOCKS = 1024;
	localparam int DEF_LEVELS          = 11;
	localparam int DEF_MIN_BLOCK_BYTES = 1024;

	localparam int ADDR_W = 40;
	localparam int SIZE_W = 32;
	localparam int STAT_W = 3;

	localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
	localparam logic [STAT_W-1:0] ST_TOO_LARGE = 3'd1;
	localparam logic [STAT_W-1:0] ST_NO_SPACE  = 3'd2;
	localparam logic [STAT_W-1:0] ST_NOT_ALLOC = 3'd3;
	localparam logic [STAT_W-1:0] ST_OUTSIDE   = 3'd4;

	localparam logic FUNC_FREE = 1'b1;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_A_CHK,
		S_SCAN_RD,
		S_SCAN_EV,
		S_SPLIT_RD,
		S_SPLIT_WR,
		S_TAG_WR,
		S_F_CHK,
		S_TAG_EV,
		S_MERGE_RD,
		S_MERGE_WR,
		S_DONE
	} state_t;

	// bit edits applied to one bitmap word
	typedef struct packed {
		logic a_wr;
		logic a_val;
		logic b_wr;
		logic b_val;
	} wmod_t;

endpackage

@@ hw/rtl/bba_ram.sv @@
// generic simple dual-port ram with registered read
module bba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hw/rtl/bba_word_unit.sv @@
// shared bitmap word unit: lowest free bit in a level range, and bit edits
module bba_word_unit #(
	parameter int FW = 64,
	parameter int FB = 6,
	parameter int WA = 5,
	parameter int GW = 11
) (
	input  logic [FW-1:0]     data,
	input  logic [WA-1:0]     word_idx,
	input  logic [GW-1:0]     lo,
	input  logic [GW-1:0]     hi,
	input  logic [FB-1:0]     pa,
	input  logic [FB-1:0]     pb,
	input  bba_pkg::wmod_t    wmod,
	output logic              hit,
	output logic [FB-1:0]     hit_pos,
	output logic              b_bit,
	output logic [FW-1:0]     new_word
);
	import bba_pkg::*;

	logic [FW-1:0] m;
	logic [FW-1:0] low;
	logic [GW-1:0] gb;

	// free bits that belong to the level
	always_comb begin
		m = '0;
		gb = '0;
		for (int b = 0; b < FW; b++) begin
			gb = {word_idx, FB'(b)};
			m[b] = data[b] && (gb >= lo) && (gb < hi);
		end
	end

	// isolate lowest set bit, then encode it
	always_comb begin
		low = m & (~m + FW'(1));
		hit = |m;
		hit_pos = '0;
		for (int b = 0; b < FW; b++) begin
			if (low[b]) begin
				hit_pos = hit_pos | FB'(b);
			end
		end
	end

	always_comb begin
		new_word = data;
		if (wmod.a_wr) begin
			new_word[pa] = wmod.a_val;
		end
		if (wmod.b_wr) begin
			new_word[pb] = wmod.b_val;
		end
		b_bit = data[pb];
	end

endmodule

@@ hw/rtl/buddy_block_allocator_core.sv @@
// buddy block allocator top level: sequencer, bitmap and tag memories, result register
//
// channel  dir  handshake           words
// in       in   in_valid/in_stall   func, request_size, block_address
// out      out  out_valid/out_stall status, address, level, used_blocks
// cfg      in   cfg_we              cfg_data (pool_base)
//
// allocate: a decode, a scan of the bitmap words over the searched levels, then
//   a split pass at the found level and each level below it down to the
//   request, then the tag write; a rejected size ends after the decode
// free: a range check and a tag read, then a merge pass per level visited
//   (at least one); an address outside the pool or an untagged block ends early
// after the clearing pass every bitmap edit is a read-modify-write through
//   the one word unit and the single bitmap memory
// after reset a clearing pass fills the tag memory and the bitmap; no word
//   is accepted during it
// in_stall is high while a word is in work, until its result has moved into
//   the output register; a finished result waits there and a new word may be
//   accepted meanwhile, the next result then holds in its last state
module buddy_block_allocator_core #(
	parameter int SMALLEST_BLOCKS = bba_pkg::DEF_SMALLEST_BLOCKS,
	parameter int LEVELS          = bba_pkg::DEF_LEVELS,
	parameter int MIN_BLOCK_BYTES = bba_pkg::DEF_MIN_BLOCK_BYTES,
	localparam int LOG_S = $clog2(SMALLEST_BLOCKS),
	localparam int LW    = $clog2(LEVELS),
	localparam int UW    = LOG_S + 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bba_pkg::ADDR_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          func,
	input  logic [bba_pkg::SIZE_W-1:0]    request_size,
	input  logic [bba_pkg::ADDR_W-1:0]    block_address,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bba_pkg::STAT_W-1:0]    status,
	output logic [bba_pkg::ADDR_W-1:0]    address,
	output logic [LW-1:0]                 level,
	output logic [UW-1:0]                 used_blocks
);
	import bba_pkg::*;

	localparam int TWO_S   = 2 * SMALLEST_BLOCKS;
	localparam int FW      = (TWO_S >= 64) ? 64 : TWO_S;
	localparam int FB      = $clog2(FW);
	localparam int NWORDS  = TWO_S / FW;
	localparam int WA      = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int GW      = WA + FB;
	localparam int TW      = $clog2(LEVELS + 1);
	localparam int LOG_MIN = $clog2(MIN_BLOCK_BYTES);
	localparam int TOP_POS = (TWO_S - 2) % FW;
	localparam longint POOL_BYTES = longint'(SMALLEST_BLOCKS) * longint'(MIN_BLOCK_BYTES);
	localparam logic [TW-1:0] TAG_NONE = '1;
	localparam logic [LW-1:0] TOP_LVL  = LW'(LEVELS - 1);

	function automatic logic [GW-1:0] lvl_base(input logic [LW-1:0] l);
		lvl_base = GW'(TWO_S - (TWO_S >> l));
	endfunction

	function automatic logic [GW-1:0] lvl_hi(input logic [LW-1:0] l);
		lvl_hi = GW'(TWO_S - (TWO_S >> l) + (SMALLEST_BLOCKS >> l));
	endfunction

	state_t state_q, state_d;

	logic [ADDR_W-1:0] pool_base_q;
	logic [UW-1:0]     used_q;
	logic [LOG_S-1:0]  clr_cnt_q;
	logic              out_valid_q;

	logic              func_q;
	logic [SIZE_W-1:0] size_q;
	logic [ADDR_W-1:0] baddr_q;
	logic [LW-1:0]     lvl_q;
	logic [LW-1:0]     cur_l_q;
	logic [WA-1:0]     word_q;
	logic [LOG_S-1:0]  off_q;
	logic              split_lower_q;
	logic [LOG_S-1:0]  tag_idx_q;
	logic [STAT_W-1:0] rs_status_q;
	logic [ADDR_W-1:0] rs_addr_q;
	logic [LW-1:0]     rs_level_q;
	logic [STAT_W-1:0] status_q;
	logic [ADDR_W-1:0] address_q;
	logic [LW-1:0]     level_q;
	logic [UW-1:0]     used_out_q;

	// memory ports
	logic          fm_we;
	logic [WA-1:0] fm_waddr, fm_raddr;
	logic [FW-1:0] fm_wdata, fm_rdata;
	logic             tag_we;
	logic [LOG_S-1:0] tag_waddr, tag_raddr;
	logic [TW-1:0]    tag_wdata, tag_rdata;

	// word unit
	wmod_t         wmod;
	logic          wu_hit, wu_b_bit;
	logic [FB-1:0] wu_hit_pos, wu_pb;
	logic [FW-1:0] wu_new_word;
	logic [GW-1:0] lo_cur, hi_cur, g_cur, g_hit, last_g;

	// request decode
	logic [LEVELS-1:0] fits;
	logic [LW-1:0]     req_lvl;
	logic              no_room;
	logic [ADDR_W:0]   rel;
	logic              outside;
	logic [LOG_S-1:0]  mb;
	logic              accept, out_free, clr_last, word_last;

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign clr_last = (clr_cnt_q == LOG_S'(SMALLEST_BLOCKS - 1));

	assign lo_cur    = lvl_base(cur_l_q);
	assign hi_cur    = lvl_hi(cur_l_q);
	assign g_cur     = lo_cur + GW'(off_q);
	assign g_hit     = {word_q, wu_hit_pos} - lo_cur;
	assign last_g    = hi_cur - GW'(1);
	assign word_last = (word_q == last_g[GW-1:FB]);

	// smallest level whose block holds the size
	always_comb begin
		req_lvl = '0;
		for (int l = 0; l < LEVELS; l++) begin
			fits[l] = ({1'b0, size_q} <= (33'(MIN_BLOCK_BYTES) << l));
		end
		for (int l = LEVELS - 1; l >= 0; l--) begin
			if (fits[l]) begin
				req_lvl = LW'(l);
			end
		end
		no_room = ((UW + 1)'(used_q) + ((UW + 1)'(1) << req_lvl))
			> (UW + 1)'(SMALLEST_BLOCKS);
	end

	// free address range check and minimum block index
	assign rel     = {1'b0, baddr_q} - {1'b0, pool_base_q};
	assign outside = rel[ADDR_W] || (rel[ADDR_W-1:0] >= ADDR_W'(POOL_BYTES));
	assign mb      = rel[LOG_S+LOG_MIN-1:LOG_MIN];

	// split edits o and o+1, merge tests the buddy o^1
	assign wu_pb = (state_q == S_MERGE_WR) ? (g_cur[FB-1:0] ^ FB'(1))
		: (g_cur[FB-1:0] | FB'(1));

	bba_ram #(.WIDTH(FW), .DEPTH(NWORDS)) u_free_map (
		.clk   (clk),
		.we    (fm_we),
		.waddr (fm_waddr),
		.wdata (fm_wdata),
		.raddr (fm_raddr),
		.rdata (fm_rdata)
	);

	bba_ram #(.WIDTH(TW), .DEPTH(SMALLEST_BLOCKS)) u_tag_mem (
		.clk   (clk),
		.we    (tag_we),
		.waddr (tag_waddr),
		.wdata (tag_wdata),
		.raddr (tag_raddr),
		.rdata (tag_rdata)
	);

	bba_word_unit #(.FW(FW), .FB(FB), .WA(WA), .GW(GW)) u_word (
		.data     (fm_rdata),
		.word_idx (word_q),
		.lo       (lo_cur),
		.hi       (hi_cur),
		.pa       (g_cur[FB-1:0]),
		.pb       (wu_pb),
		.wmod     (wmod),
		.hit      (wu_hit),
		.hit_pos  (wu_hit_pos),
		.b_bit    (wu_b_bit),
		.new_word (wu_new_word)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR:    if (clr_last) state_d = S_IDLE;
			S_IDLE: begin
				if (accept) begin
					state_d = (func == FUNC_FREE) ? S_F_CHK : S_A_CHK;
				end
			end
			S_A_CHK:    state_d = (!(|fits) || no_room) ? S_DONE : S_SCAN_RD;
			S_SCAN_RD:  state_d = S_SCAN_EV;
			S_SCAN_EV: begin
				priority if (wu_hit) state_d = S_SPLIT_RD;
				else if (!word_last) state_d = S_SCAN_RD;
				else if (cur_l_q == TOP_LVL) state_d = S_DONE;
				else state_d = S_SCAN_RD;
			end
			S_SPLIT_RD: state_d = S_SPLIT_WR;
			S_SPLIT_WR: state_d = (cur_l_q == lvl_q) ? S_TAG_WR : S_SPLIT_RD;
			S_TAG_WR:   state_d = S_DONE;
			S_F_CHK:    state_d = outside ? S_DONE : S_TAG_EV;
			S_TAG_EV:   state_d = (tag_rdata >= TW'(LEVELS)) ? S_DONE : S_MERGE_RD;
			S_MERGE_RD: state_d = S_MERGE_WR;
			S_MERGE_WR: begin
				if (cur_l_q == TOP_LVL || !wu_b_bit) state_d = S_DONE;
				else state_d = S_MERGE_RD;
			end
			S_DONE:     if (out_free) state_d = S_IDLE;
			default:    state_d = S_CLEAR;
		endcase
	end

	// memory and word unit controls
	always_comb begin
		fm_we     = 1'b0;
		fm_waddr  = g_cur[GW-1:FB];
		fm_wdata  = wu_new_word;
		fm_raddr  = g_cur[GW-1:FB];
		tag_we    = 1'b0;
		tag_waddr = tag_idx_q;
		tag_wdata = TAG_NONE;
		tag_raddr = mb;
		wmod      = '0;
		in_stall  = (state_q != S_IDLE);
		unique case (state_q)
			S_CLEAR: begin
				fm_we     = ((LOG_S + 1)'(clr_cnt_q) < (LOG_S + 1)'(NWORDS));
				fm_waddr  = clr_cnt_q[WA-1:0];
				fm_wdata  = (clr_cnt_q == LOG_S'(NWORDS - 1)) ? (FW'(1) << TOP_POS) : '0;
				tag_we    = 1'b1;
				tag_waddr = clr_cnt_q;
			end
			S_SCAN_RD: fm_raddr = word_q;
			S_SPLIT_WR: begin
				fm_we = 1'b1;
				wmod  = '{a_wr: 1'b1, a_val: 1'b0, b_wr: split_lower_q, b_val: 1'b1};
			end
			S_TAG_WR: begin
				tag_we    = 1'b1;
				tag_waddr = off_q << lvl_q;
				tag_wdata = TW'(lvl_q);
			end
			S_TAG_EV: begin
				tag_we = (tag_rdata < TW'(LEVELS));
			end
			S_MERGE_WR: begin
				fm_we = 1'b1;
				if (cur_l_q == TOP_LVL || !wu_b_bit) begin
					wmod = '{a_wr: 1'b1, a_val: 1'b1, b_wr: 1'b0, b_val: 1'b0};
				end else begin
					wmod = '{a_wr: 1'b1, a_val: 1'b0, b_wr: 1'b1, b_val: 1'b0};
				end
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			pool_base_q <= '0;
			used_q      <= '0;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				pool_base_q <= cfg_data;
			end
			if (state_q == S_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + LOG_S'(1);
			end
			if (state_q == S_TAG_WR) begin
				used_q <= used_q + (UW'(1) << lvl_q);
			end
			if (state_q == S_MERGE_WR && state_d == S_DONE) begin
				used_q <= used_q - (UW'(1) << lvl_q);
			end
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					func_q      <= func;
					size_q      <= request_size;
					baddr_q     <= block_address;
					rs_status_q <= ST_OK;
					rs_addr_q   <= '0;
					rs_level_q  <= '0;
				end
			end
			S_A_CHK: begin
				lvl_q   <= req_lvl;
				cur_l_q <= req_lvl;
				word_q  <= WA'(lvl_base(req_lvl) >> FB);
				if (!(|fits)) rs_status_q <= ST_TOO_LARGE;
				else if (no_room) rs_status_q <= ST_NO_SPACE;
			end
			S_SCAN_EV: begin
				priority if (wu_hit) begin
					off_q         <= g_hit[LOG_S-1:0];
					split_lower_q <= 1'b0;
				end else if (!word_last) begin
					word_q <= word_q + WA'(1);
				end else if (cur_l_q == TOP_LVL) begin
					rs_status_q <= ST_NO_SPACE;
				end else begin
					cur_l_q <= cur_l_q + LW'(1);
					word_q  <= WA'(lvl_base(cur_l_q + LW'(1)) >> FB);
				end
			end
			S_SPLIT_WR: begin
				if (cur_l_q != lvl_q) begin
					cur_l_q       <= cur_l_q - LW'(1);
					off_q         <= off_q << 1;
					split_lower_q <= 1'b1;
				end
			end
			S_TAG_WR: begin
				rs_addr_q  <= pool_base_q + (ADDR_W'(off_q << lvl_q) << LOG_MIN);
				rs_level_q <= lvl_q;
			end
			S_F_CHK: begin
				tag_idx_q <= mb;
				if (outside) rs_status_q <= ST_OUTSIDE;
			end
			S_TAG_EV: begin
				if (tag_rdata >= TW'(LEVELS)) begin
					rs_status_q <= ST_NOT_ALLOC;
				end else begin
					lvl_q      <= tag_rdata[LW-1:0];
					cur_l_q    <= tag_rdata[LW-1:0];
					rs_level_q <= tag_rdata[LW-1:0];
					off_q      <= tag_idx_q >> tag_rdata;
				end
			end
			S_MERGE_WR: begin
				cur_l_q <= cur_l_q + LW'(1);
				off_q   <= off_q >> 1;
			end
			S_DONE: begin
				if (out_free) begin
					status_q   <= rs_status_q;
					address_q  <= rs_addr_q;
					level_q    <= rs_level_q;
					used_out_q <= used_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign address     = address_q;
	assign level       = level_q;
	assign used_blocks = used_out_q;

	// checks
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> used_blocks <= UW'(SMALLEST_BLOCKS))
		else $error("used count above pool size");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ST_OUTSIDE)
		else $error("bad status code");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> address == '0 && level == '0)
		else $error("failed result carries address or level");

	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q != S_IDLE)
		else $error("accepted word not started");

	a_free_addr: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MERGE_WR |-> func_q == FUNC_FREE)
		else $error("merge outside a free");

endmodule
